### hdl/fhm_pkg.sv
// Package with the shared types, codes and sizes of the queued mutex.
package fhm_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TID_W       = 4;
    localparam int IDX_W       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int WAIT_W      = 5;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_QUEUED   = 3'd2,
        ST_HANDOFF  = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NOTOWNER = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    localparam logic FUNC_LOCK   = 1'b0;
    localparam logic FUNC_UNLOCK = 1'b1;

    typedef struct packed {
        logic             func;
        logic [TID_W-1:0] thread_id;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [TID_W-1:0]  woken_thread;
        logic              locked_now;
        logic [TID_W-1:0]  owner_now;
        logic [WAIT_W-1:0] waiting_now;
    } t_rsp;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic commit;
    } t_dp_cmd;

    // Status from the controller about the handshake state.
    typedef struct packed {
        logic in_ready;
        logic out_valid;
    } t_ctl_stat;

endpackage

### hdl/fifo_handoff_mutex.sv
// Top level of the queued mutex with direct ownership handoff.
//
// Requests enter on the input channel (i_in_valid, o_in_ready, i_in_data), each a
// lock or an unlock with the requesting thread's id. Every request gives exactly
// one result on the output channel (o_out_valid, i_out_ready, o_out_data) with
// the outcome, the woken thread on a handoff, and the lock state after it.
// A request is decided and the mutex state updated in the cycle of its transfer;
// the result register is loaded together with the new state. One request can be
// taken every cycle while the receiver accepts results, as each updates only a few
// registers and one ring entry and the result register empties as it is refilled.
// Threads that must wait are kept in a ring of MAX_THREADS entries.
// While the receiver stalls the result holds, and one further request is
// accepted only in the cycle in which the held result is transferred.
// A synchronous reset leaves the mutex free, the ring empty and no result
// pending; the ring contents themselves are not cleared.
module fifo_handoff_mutex (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fhm_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fhm_pkg::t_rsp  o_out_data
);
    import fhm_pkg::*;

    t_dp_cmd   cmd;
    t_ctl_stat stat;

    fhm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .o_stat      (stat)
    );

    fhm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

    assign o_in_ready  = stat.in_ready;
    assign o_out_valid = stat.out_valid;

endmodule

### hdl/fhm_ctrl.sv
// Handshake controller: tracks whether the result register holds an untaken result.
module fhm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output fhm_pkg::t_dp_cmd    o_cmd,
    output fhm_pkg::t_ctl_stat  o_stat
);
    import fhm_pkg::*;

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_HOLD  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   take_in;

    // A new request may enter when the result register is empty or is being emptied.
    assign in_ready = (r_state == S_EMPTY) || i_out_ready;
    assign take_in  = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: begin
                if (take_in) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_out_ready && !take_in) begin
                    n_state = S_EMPTY;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.commit     = take_in;
    assign o_stat.in_ready  = in_ready;
    assign o_stat.out_valid = (r_state == S_HOLD);

endmodule

### hdl/fhm_datapath.sv
// Datapath: ownership registers, the ring of waiting threads and the result register.
module fhm_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fhm_pkg::t_dp_cmd  i_cmd,
    input  fhm_pkg::t_req     i_req,
    output fhm_pkg::t_rsp     o_rsp
);
    import fhm_pkg::*;

    logic             r_locked;
    logic [TID_W-1:0] r_owner;
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [TID_W-1:0] r_ring [MAX_THREADS];
    t_rsp             r_rsp;

    logic             n_locked;
    logic [TID_W-1:0] n_owner;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] n_count;
    t_status          status;
    logic [TID_W-1:0] woken;
    logic             push;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail;
    logic [TID_W-1:0] head_tid;

    // The tail position is below twice the ring depth, so one subtraction wraps it.
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail     = (tail_sum >= SUM_W'(MAX_THREADS))
                      ? IDX_W'(tail_sum - SUM_W'(MAX_THREADS)) : IDX_W'(tail_sum);
    assign head_tid = r_ring[r_head];

    always_comb begin
        n_locked = r_locked;
        n_owner  = r_owner;
        n_head   = r_head;
        n_count  = r_count;
        woken    = '0;
        push     = 1'b0;
        status   = ST_NOTOWNER;
        if (i_req.func == FUNC_LOCK) begin
            if (!r_locked) begin
                n_locked = 1'b1;
                n_owner  = i_req.thread_id;
                status   = ST_GRANTED;
            end else if (r_owner == i_req.thread_id) begin
                status = ST_ALREADY;
            end else if (r_count >= CNT_W'(MAX_THREADS)) begin
                status = ST_FULL;
            end else begin
                push    = 1'b1;
                n_count = r_count + CNT_W'(1);
                status  = ST_QUEUED;
            end
        end else if (r_locked && (r_owner == i_req.thread_id)) begin
            if (r_count != '0) begin
                woken   = head_tid;
                n_owner = head_tid;
                n_count = r_count - CNT_W'(1);
                n_head  = (r_head == IDX_W'(MAX_THREADS - 1)) ? '0 : r_head + IDX_W'(1);
                status  = ST_HANDOFF;
            end else begin
                n_locked = 1'b0;
                n_owner  = '0;
                status   = ST_RELEASED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_owner  <= '0;
            r_head   <= '0;
            r_count  <= '0;
        end else if (i_cmd.commit) begin
            r_locked <= n_locked;
            r_owner  <= n_owner;
            r_head   <= n_head;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && push) begin
            r_ring[tail] <= i_req.thread_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.status       <= status;
            r_rsp.woken_thread <= woken;
            r_rsp.locked_now   <= n_locked;
            r_rsp.owner_now    <= n_locked ? n_owner : '0;
            r_rsp.waiting_now  <= WAIT_W'(n_count);
        end
    end

    assign o_rsp = r_rsp;

endmodule

### tb/sv/fifo_handoff_mutex_test.sv
// Self-checking testbench for the queued mutex with ownership handoff.
module fifo_handoff_mutex_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fhm_pkg::*;

    localparam int RANDOM_REQS = 1800;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_TICKS = 10;

    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp rsp;
    } t_script_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_req  i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_rsp  o_out_data;

    fifo_handoff_mutex u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predicted state of the mutex.
    logic                held;
    logic [TID_W-1:0]    holder;
    logic [TID_W-1:0]    sleepers [MAX_THREADS];
    int                  ring_head;
    int                  n_waiting;

    t_rsp          rsp_due [$];
    t_script_row   script [$];
    t_script_row   cur_row;
    int            n_bad;
    int            n_total;
    int            n_issued;
    int            n_accepted;
    bit            req_pending;
    int            send_gap;
    int            recv_stall;
    int            unlock_pct;

    function automatic t_rsp mutex_apply(t_req req);
        t_rsp r;
        int   tail;
        r = '0;
        if (req.func == FUNC_LOCK) begin
            if (!held) begin
                held   = 1'b1;
                holder = req.thread_id;
                r.status = ST_GRANTED;
            end else if (holder == req.thread_id) begin
                r.status = ST_ALREADY;
            end else if (n_waiting >= MAX_THREADS) begin
                r.status = ST_FULL;
            end else begin
                tail = (ring_head + n_waiting) % MAX_THREADS;
                sleepers[tail] = req.thread_id;
                n_waiting++;
                r.status = ST_QUEUED;
            end
        end else begin
            if (held && holder == req.thread_id) begin
                if (n_waiting > 0) begin
                    r.woken_thread = sleepers[ring_head];
                    holder         = sleepers[ring_head];
                    ring_head      = (ring_head + 1) % MAX_THREADS;
                    n_waiting--;
                    r.status = ST_HANDOFF;
                end else begin
                    held   = 1'b0;
                    holder = '0;
                    r.status = ST_RELEASED;
                end
            end else begin
                r.status = ST_NOTOWNER;
            end
        end
        r.locked_now  = held;
        r.owner_now   = held ? holder : '0;
        r.waiting_now = WAIT_W'(n_waiting);
        return r;
    endfunction

    function automatic t_script_row step_row(logic fn, logic [TID_W-1:0] tid);
        t_script_row row;
        row = '0;
        row.req.func      = fn;
        row.req.thread_id = tid;
        return row;
    endfunction

    function automatic t_script_row known_row(logic fn, logic [TID_W-1:0] tid, t_status st,
                                              logic [TID_W-1:0] woken, logic lk,
                                              logic [TID_W-1:0] own, logic [WAIT_W-1:0] nw);
        t_script_row row;
        row = step_row(fn, tid);
        row.typed = 1'b1;
        row.rsp   = '{st, woken, lk, own, nw};
        return row;
    endfunction

    // Lock requests and unlocks by the holder, with some stray unlocks.
    // The unlock share swings so that the queue both fills up and drains.
    function automatic t_req random_request();
        t_req r;
        int   roll;
        roll        = $urandom_range(0, 99);
        r.thread_id = TID_W'($urandom_range(0, MAX_THREADS - 1));
        if (roll < 8) begin
            r.func = FUNC_UNLOCK;
        end else if (held && roll < 8 + unlock_pct) begin
            r.func      = FUNC_UNLOCK;
            r.thread_id = holder;
        end else begin
            r.func = FUNC_LOCK;
        end
        return r;
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            n_bad++;
        end
    endfunction

    task automatic run_cycle();
        t_rsp want;
        t_rsp got;
        @(posedge i_clk);

        if (o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (rsp_due.size() == 0) begin
                $display("%0t: result with none expected, got %h", $time, got);
                n_bad++;
            end else begin
                want = rsp_due.pop_front();
                compare_field("status", 8'(want.status), 8'(got.status));
                compare_field("woken_thread", 8'(want.woken_thread), 8'(got.woken_thread));
                compare_field("locked_now", 8'(want.locked_now), 8'(got.locked_now));
                compare_field("owner_now", 8'(want.owner_now), 8'(got.owner_now));
                compare_field("waiting_now", 8'(want.waiting_now), 8'(got.waiting_now));
            end
        end

        if (i_in_valid && o_in_ready) begin
            want = mutex_apply(i_in_data);
            rsp_due.push_back(cur_row.typed ? cur_row.rsp : want);
            n_accepted++;
            req_pending = 1'b0;
            if (n_accepted < n_total - CALM_TAIL && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 12);
        end

        // The next request is chosen only after the state above has moved on.
        if (!req_pending && n_issued < n_total && send_gap == 0) begin
            if (n_issued < script.size()) begin
                cur_row = script[n_issued];
            end else begin
                if (n_issued % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: unlock_pct = 15;
                        1: unlock_pct = 45;
                        default: unlock_pct = 80;
                    endcase
                end
                cur_row     = '0;
                cur_row.req = random_request();
            end
            i_in_valid  <= 1'b1;
            i_in_data   <= cur_row.req;
            req_pending = 1'b1;
            n_issued++;
        end else if (!req_pending) begin
            i_in_valid <= 1'b0;
            if (send_gap > 0)
                send_gap--;
        end

        if (recv_stall > 0) begin
            i_out_ready <= 1'b0;
            recv_stall--;
        end else begin
            i_out_ready <= 1'b1;
            if (n_accepted < n_total - CALM_TAIL && $urandom_range(0, 4) == 0)
                recv_stall = $urandom_range(1, 12);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;

        held        = 1'b0;
        holder      = '0;
        ring_head   = 0;
        n_waiting   = 0;
        n_bad       = 0;
        n_issued    = 0;
        n_accepted  = 0;
        req_pending = 1'b0;
        send_gap    = 0;
        recv_stall  = 0;
        unlock_pct  = 45;
        cur_row     = '0;

        script.push_back(known_row(FUNC_UNLOCK, 4'd0, ST_NOTOWNER, 4'd0, 1'b0, 4'd0, 5'd0));
        script.push_back(known_row(FUNC_LOCK, 4'd15, ST_GRANTED, 4'd0, 1'b1, 4'd15, 5'd0));
        script.push_back(known_row(FUNC_LOCK, 4'd15, ST_ALREADY, 4'd0, 1'b1, 4'd15, 5'd0));
        script.push_back(known_row(FUNC_UNLOCK, 4'd3, ST_NOTOWNER, 4'd0, 1'b1, 4'd15, 5'd0));
        for (int t = 0; t < MAX_THREADS - 1; t++)
            script.push_back(step_row(FUNC_LOCK, TID_W'(t)));
        // A thread that is already asleep queues a second time.
        script.push_back(step_row(FUNC_LOCK, 4'd0));
        script.push_back(known_row(FUNC_LOCK, 4'd7, ST_FULL, 4'd0, 1'b1, 4'd15, 5'd16));
        script.push_back(known_row(FUNC_UNLOCK, 4'd15, ST_HANDOFF, 4'd0, 1'b1, 4'd0, 5'd15));
        script.push_back(step_row(FUNC_UNLOCK, 4'd0));
        n_total = script.size() + RANDOM_REQS;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == n_total && rsp_due.size() == 0))
            run_cycle();
        repeat (DRAIN_TICKS) run_cycle();

        if (n_bad == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hdl/fhm_pkg.sv
hdl/fhm_ctrl.sv
hdl/fhm_datapath.sv
hdl/fifo_handoff_mutex.sv
tb/sv/fifo_handoff_mutex_test.sv
